/* sv/amcs_pkg.sv */
// Shared types and constants for the automated manual cruise sequencer.
// No dependencies; used by automated_manual_cruise_sequencer.
package amcs_pkg;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_PARK    = 3'd0,
        PH_PUSH    = 3'd1,
        PH_GEAR    = 3'd2,
        PH_RPM     = 3'd3,
        PH_RELEASE = 3'd4,
        PH_HOLD    = 3'd5,
        PH_DRIVE   = 3'd6,
        PH_STOP    = 3'd7
    } phase_t;

    // Clutch commands
    typedef enum logic [1:0] {
        CL_PRESS   = 2'd0,
        CL_RELEASE = 2'd1,
        CL_SLOW    = 2'd2
    } clutch_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_ENABLE = 1'b0,
        CFG_TARGET = 1'b1
    } cfg_reg_t;

    // Travel direction, two-bit signed
    localparam logic [1:0] TS_ZERO = 2'b00;
    localparam logic [1:0] TS_POS  = 2'b01;
    localparam logic [1:0] TS_NEG  = 2'b11;

    // Brake levels, Q8
    localparam logic [8:0] BRAKE_FULL   = 9'd256;
    localparam logic [8:0] BRAKE_LAUNCH = 9'd102;
    localparam logic [8:0] BRAKE_HOLD   = 9'd51;
    localparam logic [8:0] BRAKE_OFF    = 9'd0;

    // Rpm limits and thresholds
    localparam logic [13:0] RPM_FLOOR   = 14'd800;
    localparam logic [13:0] RPM_MAX     = 14'd16383;
    localparam logic [13:0] RPM_IDLE    = 14'd1000;
    localparam logic [13:0] RPM_MATCH   = 14'd500;
    localparam logic [12:0] RPM_DOWN    = 13'd1000;
    localparam logic [12:0] RPM_UP      = 13'd2000;

    // Gear codes
    localparam logic [2:0] GEAR_NEUTRAL = 3'd0;
    localparam logic [2:0] GEAR_FIRST   = 3'd1;
    localparam logic [2:0] GEAR_TOP     = 3'd5;
    localparam logic [2:0] GEAR_REVERSE = 3'd6;

    // rpm = floor(F * mag / 10000); done as (mag * ceil(F * 2^S / 10000)) >> S.
    // S = 22 keeps the rounding error below the 1/10000 step for mag <= 256.
    localparam int RECIP_SHIFT = 22;
    localparam logic [63:0] RECIP_SCALE = 64'd1 << RECIP_SHIFT;
    localparam logic [63:0] RPM_DIV = 64'd10000;
    localparam logic [28:0] RECIP_G1 =
        29'((64'd1169874 * RECIP_SCALE + RPM_DIV - 64'd1) / RPM_DIV);
    localparam logic [28:0] RECIP_G2 =
        29'((64'd676092 * RECIP_SCALE + RPM_DIV - 64'd1) / RPM_DIV);
    localparam logic [28:0] RECIP_G3 =
        29'((64'd402936 * RECIP_SCALE + RPM_DIV - 64'd1) / RPM_DIV);
    localparam logic [28:0] RECIP_G4 =
        29'((64'd309000 * RECIP_SCALE + RPM_DIV - 64'd1) / RPM_DIV);
    localparam logic [28:0] RECIP_G5 =
        29'((64'd245346 * RECIP_SCALE + RPM_DIV - 64'd1) / RPM_DIV);
    localparam logic [28:0] RECIP_G6 =
        29'((64'd1013520 * RECIP_SCALE + RPM_DIV - 64'd1) / RPM_DIV);

    function automatic logic [28:0] gear_recip(input logic [2:0] gear);
        logic [28:0] r;
        case (gear)
            3'd1:    r = RECIP_G1;
            3'd2:    r = RECIP_G2;
            3'd3:    r = RECIP_G3;
            3'd4:    r = RECIP_G4;
            3'd5:    r = RECIP_G5;
            3'd6:    r = RECIP_G6;
            default: r = 29'd0;   // neutral and unused code fall to the floor
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic [7:0]  vehicle_speed;
        logic [12:0] engine_rpm;
        logic [2:0]  gear_now;
        logic        clutch_open;
        logic        clutch_closed;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  gear_request;
        logic [1:0]  clutch_command;
        logic [8:0]  brake_level;
        logic [13:0] rpm_request;
        logic [2:0]  mode;
    } out_item_t;

endpackage

/* sv/automated_manual_cruise_sequencer.sv */
// Automated manual gearbox cruise sequencer: one control tick per request.
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while the result channel is not stalled; the rpm multiply and clamp set the path.
// Reset (aresetn low, synchronous): disabled, park phase, gear 0, rpm goal 1000,
// full brake, clutch pressed, target speed 0, both pipeline stages empty.
// Depends on amcs_pkg.
module automated_manual_cruise_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  amcs_pkg::in_item_t   s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output amcs_pkg::out_item_t  m_data,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [8:0]           cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        enable_reg;
    logic [8:0]  target_reg;      // signed target speed

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    amcs_pkg::phase_t  phase_reg,   phase_next;
    logic [2:0]        gear_reg,    gear_next;
    logic [2:0]        pending_reg, pending_next;
    logic [1:0]        sign_reg,    sign_next;
    logic              launch_reg,  launch_next;
    logic [13:0]       rpm_reg,     rpm_next;
    logic [8:0]        brake_reg,   brake_next;
    amcs_pkg::clutch_t clutch_reg,  clutch_next;

    // ------------------------------------------------------------------
    // Pipeline: input register, then result register
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    amcs_pkg::in_item_t  in_data_reg;
    logic                m_valid_reg;
    amcs_pkg::out_item_t m_data_reg;
    amcs_pkg::out_item_t out_next;
    logic                adv;

    // The tick in the input register moves on when the result slot is free
    // (or drains this cycle). A disabled tick also moves on, but yields nothing.
    assign adv       = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // ------------------------------------------------------------------
    // Speed terms
    // ------------------------------------------------------------------
    logic [7:0]         speed;
    logic [8:0]         ts_mag;        // |target|, up to 256
    logic signed [10:0] spd_s;
    logic signed [10:0] ts_s;
    logic signed [10:0] ts_abs_s;
    logic               stop_hit;      // overspeed in travel direction
    logic               park_hit;      // near standstill with zero target
    logic               resume_hit;    // target well above measured speed

    assign speed    = in_data_reg.vehicle_speed;
    assign ts_mag   = target_reg[8] ? (~target_reg + 9'd1) : target_reg;
    assign spd_s    = $signed({3'b000, speed});
    assign ts_s     = $signed({{2{target_reg[8]}}, target_reg});
    assign ts_abs_s = $signed({2'b00, ts_mag});

    always_comb begin
        stop_hit = 1'b0;
        if (sign_reg == amcs_pkg::TS_POS && (spd_s - ts_s) > 11'sd2) begin
            stop_hit = 1'b1;
        end
        if (sign_reg == amcs_pkg::TS_NEG && (spd_s + ts_s) > 11'sd2) begin
            stop_hit = 1'b1;
        end
    end

    assign park_hit   = (speed < 8'd2) && (target_reg == 9'd0);
    assign resume_hit = (ts_abs_s - spd_s) > 11'sd2;

    // ------------------------------------------------------------------
    // Rpm target: floor(factor * mag / 10000), clamped to [800, 16383].
    // Drive and stopping follow the target speed, other phases the measured.
    // ------------------------------------------------------------------
    logic [8:0]  rpm_mag;
    logic [36:0] rpm_prod;
    logic [14:0] rpm_quot;
    logic [13:0] rpm_calc;

    assign rpm_mag  = (phase_reg == amcs_pkg::PH_DRIVE || phase_reg == amcs_pkg::PH_STOP)
                      ? ts_mag : {1'b0, speed};
    assign rpm_prod = {8'd0, amcs_pkg::gear_recip(gear_reg)} * {28'd0, rpm_mag};
    assign rpm_quot = 15'(rpm_prod >> amcs_pkg::RECIP_SHIFT);

    always_comb begin
        if (rpm_quot > {1'b0, amcs_pkg::RPM_MAX}) begin
            rpm_calc = amcs_pkg::RPM_MAX;
        end else if (rpm_quot < {1'b0, amcs_pkg::RPM_FLOOR}) begin
            rpm_calc = amcs_pkg::RPM_FLOOR;
        end else begin
            rpm_calc = rpm_quot[13:0];
        end
    end

    // Rpm match error against the new goal
    logic [13:0] rpm_in;
    logic [13:0] rpm_err;
    assign rpm_in  = {1'b0, in_data_reg.engine_rpm};
    assign rpm_err = (rpm_in > rpm_calc) ? (rpm_in - rpm_calc) : (rpm_calc - rpm_in);

    // Brake while clutch is open: hold the car only during launch
    logic [8:0] brake_launch;
    assign brake_launch = launch_reg ? amcs_pkg::BRAKE_LAUNCH : amcs_pkg::BRAKE_OFF;

    // ------------------------------------------------------------------
    // Next state for one tick
    // ------------------------------------------------------------------
    always_comb begin
        phase_next   = phase_reg;
        gear_next    = gear_reg;
        pending_next = pending_reg;
        sign_next    = sign_reg;
        launch_next  = launch_reg;
        rpm_next     = rpm_reg;
        brake_next   = brake_reg;
        clutch_next  = clutch_reg;

        case (phase_reg)
            amcs_pkg::PH_PARK: begin
                clutch_next = amcs_pkg::CL_PRESS;
                brake_next  = amcs_pkg::BRAKE_LAUNCH;
                gear_next   = amcs_pkg::GEAR_NEUTRAL;
                rpm_next    = amcs_pkg::RPM_IDLE;
                sign_next   = amcs_pkg::TS_ZERO;
                launch_next = 1'b1;
                if (!target_reg[8] && target_reg != 9'd0) begin
                    phase_next   = amcs_pkg::PH_PUSH;
                    sign_next    = amcs_pkg::TS_POS;
                    pending_next = amcs_pkg::GEAR_FIRST;
                end
                if (target_reg[8]) begin
                    phase_next   = amcs_pkg::PH_PUSH;
                    sign_next    = amcs_pkg::TS_NEG;
                    pending_next = amcs_pkg::GEAR_REVERSE;
                end
            end
            amcs_pkg::PH_PUSH: begin
                clutch_next = amcs_pkg::CL_PRESS;
                brake_next  = brake_launch;
                rpm_next    = amcs_pkg::RPM_IDLE;
                if (in_data_reg.clutch_open) begin
                    phase_next = amcs_pkg::PH_GEAR;
                    gear_next  = pending_reg;
                end
                if (stop_hit) phase_next = amcs_pkg::PH_STOP;
                if (park_hit) phase_next = amcs_pkg::PH_PARK;
            end
            amcs_pkg::PH_GEAR: begin
                clutch_next = amcs_pkg::CL_PRESS;
                brake_next  = brake_launch;
                rpm_next    = amcs_pkg::RPM_IDLE;
                if (in_data_reg.gear_now == gear_reg) phase_next = amcs_pkg::PH_RPM;
                if (stop_hit) phase_next = amcs_pkg::PH_STOP;
                if (park_hit) phase_next = amcs_pkg::PH_PARK;
            end
            amcs_pkg::PH_RPM: begin
                clutch_next = amcs_pkg::CL_PRESS;
                brake_next  = brake_launch;
                rpm_next    = rpm_calc;
                if (rpm_err < amcs_pkg::RPM_MATCH) phase_next = amcs_pkg::PH_RELEASE;
                if (stop_hit) phase_next = amcs_pkg::PH_STOP;
                if (park_hit) phase_next = amcs_pkg::PH_PARK;
            end
            amcs_pkg::PH_RELEASE: begin
                clutch_next = amcs_pkg::CL_RELEASE;
                // launch ends once the clutch leaves the open stop
                launch_next = launch_reg && in_data_reg.clutch_open;
                brake_next  = amcs_pkg::BRAKE_OFF;
                rpm_next    = rpm_calc;
                if (in_data_reg.clutch_closed) phase_next = amcs_pkg::PH_DRIVE;
                // creeping faster than a very low target: slip and brake
                if ({1'b0, speed} > ts_mag && ts_mag <= 9'd7) begin
                    phase_next = amcs_pkg::PH_HOLD;
                end
                if (stop_hit) phase_next = amcs_pkg::PH_STOP;
                if (park_hit) phase_next = amcs_pkg::PH_PARK;
            end
            amcs_pkg::PH_HOLD: begin
                clutch_next = amcs_pkg::CL_SLOW;
                brake_next  = amcs_pkg::BRAKE_HOLD;
                rpm_next    = rpm_calc;
                if (resume_hit) phase_next = amcs_pkg::PH_RELEASE;
                if (stop_hit) phase_next = amcs_pkg::PH_STOP;
                if (park_hit) phase_next = amcs_pkg::PH_PARK;
            end
            amcs_pkg::PH_DRIVE: begin
                clutch_next = amcs_pkg::CL_RELEASE;
                brake_next  = amcs_pkg::BRAKE_OFF;
                rpm_next    = rpm_calc;
                // downshift on lugging, forward gears 2..5 only
                if (in_data_reg.engine_rpm < amcs_pkg::RPM_DOWN
                    && gear_reg > amcs_pkg::GEAR_FIRST
                    && gear_reg <= amcs_pkg::GEAR_TOP) begin
                    phase_next   = amcs_pkg::PH_PUSH;
                    pending_next = gear_reg - 3'd1;
                end
                // upshift on overrev below top gear
                if (in_data_reg.engine_rpm > amcs_pkg::RPM_UP
                    && gear_reg < amcs_pkg::GEAR_TOP) begin
                    phase_next   = amcs_pkg::PH_PUSH;
                    pending_next = gear_reg + 3'd1;
                end
                if (stop_hit) phase_next = amcs_pkg::PH_STOP;
                if (park_hit) phase_next = amcs_pkg::PH_PARK;
            end
            default: begin
                // stopping: slip the clutch with light brake
                clutch_next = amcs_pkg::CL_SLOW;
                brake_next  = amcs_pkg::BRAKE_HOLD;
                rpm_next    = rpm_calc;
                if (resume_hit) phase_next = amcs_pkg::PH_RELEASE;
                if (park_hit) phase_next = amcs_pkg::PH_PARK;
            end
        endcase

        out_next.gear_request   = gear_next;
        out_next.clutch_command = clutch_next;
        out_next.brake_level    = brake_next;
        out_next.rpm_request    = rpm_next;
        out_next.mode           = phase_next;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            target_reg  <= 9'd0;
            phase_reg   <= amcs_pkg::PH_PARK;
            gear_reg    <= amcs_pkg::GEAR_NEUTRAL;
            pending_reg <= amcs_pkg::GEAR_NEUTRAL;
            sign_reg    <= amcs_pkg::TS_ZERO;
            launch_reg  <= 1'b1;
            rpm_reg     <= amcs_pkg::RPM_IDLE;
            brake_reg   <= amcs_pkg::BRAKE_FULL;
            clutch_reg  <= amcs_pkg::CL_PRESS;
        end else if (cfg_valid) begin
            // config must arrive only while idle so it never meets a tick; the block does not enforce this
            case (cfg_index)
                amcs_pkg::CFG_ENABLE: begin
                    enable_reg <= cfg_data[0];
                    if (!cfg_data[0]) begin
                        // disable returns the sequencer state and target to reset values
                        target_reg  <= 9'd0;
                        phase_reg   <= amcs_pkg::PH_PARK;
                        gear_reg    <= amcs_pkg::GEAR_NEUTRAL;
                        pending_reg <= amcs_pkg::GEAR_NEUTRAL;
                        sign_reg    <= amcs_pkg::TS_ZERO;
                        launch_reg  <= 1'b1;
                        rpm_reg     <= amcs_pkg::RPM_IDLE;
                        brake_reg   <= amcs_pkg::BRAKE_FULL;
                        clutch_reg  <= amcs_pkg::CL_PRESS;
                    end
                end
                amcs_pkg::CFG_TARGET: begin
                    target_reg <= cfg_data;
                end
                default: begin
                    target_reg <= target_reg;
                end
            endcase
        end else if (adv && enable_reg) begin
            phase_reg   <= phase_next;
            gear_reg    <= gear_next;
            pending_reg <= pending_next;
            sign_reg    <= sign_next;
            launch_reg  <= launch_next;
            rpm_reg     <= rpm_next;
            brake_reg   <= brake_next;
            clutch_reg  <= clutch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= enable_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv && enable_reg) begin
            m_data_reg <= out_next;
        end
    end

endmodule

/* tb/automated_manual_cruise_sequencer_tb.sv */
`timescale 1ns / 100ps
// Testbench for automated_manual_cruise_sequencer: a directed script, then guided random
// requests, with every command checked against an in-bench sequencer model or a pinned value.
// Depends on amcs_pkg and automated_manual_cruise_sequencer.
module automated_manual_cruise_sequencer_tb;
    import amcs_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 5;
    localparam int MAX_IDLE        = 13;    // longest gap / stall drawn per request
    localparam int SETTLE_CYCLES   = 4;     // pipeline is two deep; covers a silent request
    localparam int TAIL_CYCLES     = 8;
    localparam int STALL_LIMIT     = 2000;  // cycles with no handshake at all
    localparam int RANDOM_TICKS    = 1950;
    localparam int MAX_REPORTS     = 10;
    localparam int SPEED_BAND      = 2;     // overspeed / underspeed margin
    localparam int HOLD_TARGET_MAX = 7;     // creep targets that use clutch hold
    localparam int RPM_IN_MAX      = 8191;

    // Gear ratio times final drive, scaled by 10000; neutral and code 7 give nothing.
    localparam longint unsigned GEAR_FACTOR [8] =
        '{0, 1169874, 676092, 402936, 309000, 245346, 1013520, 0};

    typedef struct {
        bit         is_cfg;
        cfg_reg_t   reg_sel;
        logic [8:0] wdata;
        in_item_t   req;
        bit         pinned;     // command typed in below instead of predicted
        out_item_t  want;
    } step_row_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_reg_t   cfg_index = CFG_ENABLE;
    logic [8:0] cfg_data  = '0;

    // Sequencer model state, mirrors the block's registers
    bit          seq_en;
    int          seq_target;
    phase_t      seq_phase;
    logic [2:0]  seq_gear;
    logic [2:0]  seq_next_gear;
    int          seq_dir;       // -1 reverse, 0 none, +1 forward
    bit          seq_launch;
    logic [13:0] seq_rpm;
    logic [8:0]  seq_brake;
    clutch_t     seq_clutch;

    out_item_t commands_due[$];     // predicted commands, oldest first
    int        fail_count    = 0;
    int        ticks_checked = 0;
    int        idle_cycles   = 0;
    bit        quiet         = 1'b0;    // no gaps, no stalls in this stretch
    bit        draining      = 1'b0;

    automated_manual_cruise_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin : clock_gen
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    //------------------------------------------------------------------
    // Sequencer model
    //------------------------------------------------------------------

    // floor(factor * speed / 10000), kept between the rpm floor and 14-bit max
    function automatic logic [13:0] gear_rpm_target(logic [2:0] gear, int unsigned mag);
        longint unsigned prod;
        prod = GEAR_FACTOR[gear] * mag / 10000;
        if (prod < RPM_FLOOR) prod = RPM_FLOOR;
        if (prod > RPM_MAX) prod = RPM_MAX;
        return prod[13:0];
    endfunction

    // Disabled: everything back to park, target cleared
    task automatic park_sequencer();
        seq_en        = 1'b0;
        seq_target    = 0;
        seq_phase     = PH_PARK;
        seq_gear      = GEAR_NEUTRAL;
        seq_next_gear = GEAR_NEUTRAL;
        seq_dir       = 0;
        seq_launch    = 1'b1;
        seq_rpm       = RPM_IDLE;
        seq_brake     = BRAKE_FULL;
        seq_clutch    = CL_PRESS;
    endtask

    // Overspeed in the travel direction -> stopping; standstill at zero target -> park
    task automatic stop_or_park(int spd);
        int signed_spd;
        signed_spd = seq_dir * spd;
        if (seq_dir > 0 && signed_spd - seq_target > SPEED_BAND) seq_phase = PH_STOP;
        if (seq_dir < 0 && signed_spd - seq_target < -SPEED_BAND) seq_phase = PH_STOP;
        if (spd < SPEED_BAND && seq_target == 0) seq_phase = PH_PARK;
    endtask

    task automatic step_sequencer(input in_item_t req, output bit emits,
                                  output out_item_t cmd);
        int spd;
        int ts_abs;
        int rpm_diff;
        spd    = int'(req.vehicle_speed);
        ts_abs = (seq_target < 0) ? -seq_target : seq_target;
        emits  = seq_en;
        cmd    = '0;
        if (!seq_en) return;
        case (seq_phase)
            PH_PARK: begin
                seq_clutch = CL_PRESS;
                seq_brake  = BRAKE_LAUNCH;
                seq_gear   = GEAR_NEUTRAL;
                seq_rpm    = RPM_IDLE;
                seq_dir    = 0;
                seq_launch = 1'b1;
                if (seq_target > 0) begin
                    seq_phase     = PH_PUSH;
                    seq_dir       = 1;
                    seq_next_gear = GEAR_FIRST;
                end
                if (seq_target < 0) begin
                    seq_phase     = PH_PUSH;
                    seq_dir       = -1;
                    seq_next_gear = GEAR_REVERSE;
                end
            end
            PH_PUSH: begin
                seq_clutch = CL_PRESS;
                seq_brake  = seq_launch ? BRAKE_LAUNCH : BRAKE_OFF;
                seq_rpm    = RPM_IDLE;
                if (req.clutch_open) begin
                    seq_phase = PH_GEAR;
                    seq_gear  = seq_next_gear;
                end
                stop_or_park(spd);
            end
            PH_GEAR: begin
                seq_clutch = CL_PRESS;
                seq_brake  = seq_launch ? BRAKE_LAUNCH : BRAKE_OFF;
                seq_rpm    = RPM_IDLE;
                if (req.gear_now == seq_gear) seq_phase = PH_RPM;
                stop_or_park(spd);
            end
            PH_RPM: begin
                seq_clutch = CL_PRESS;
                seq_brake  = seq_launch ? BRAKE_LAUNCH : BRAKE_OFF;
                seq_rpm    = gear_rpm_target(seq_gear, spd);
                rpm_diff   = int'(req.engine_rpm) - int'(seq_rpm);
                if (rpm_diff < int'(RPM_MATCH) && rpm_diff > -int'(RPM_MATCH))
                    seq_phase = PH_RELEASE;
                stop_or_park(spd);
            end
            PH_RELEASE: begin
                seq_clutch = CL_RELEASE;
                // launch ends on the first tick the clutch is not fully open
                if (!(seq_launch && req.clutch_open)) seq_launch = 1'b0;
                seq_brake = BRAKE_OFF;
                seq_rpm   = gear_rpm_target(seq_gear, spd);
                if (req.clutch_closed) seq_phase = PH_DRIVE;
                if (spd > ts_abs && ts_abs <= HOLD_TARGET_MAX) seq_phase = PH_HOLD;
                stop_or_park(spd);
            end
            PH_HOLD: begin
                seq_clutch = CL_SLOW;
                seq_brake  = BRAKE_HOLD;
                seq_rpm    = gear_rpm_target(seq_gear, spd);
                if (ts_abs - spd > SPEED_BAND) seq_phase = PH_RELEASE;
                stop_or_park(spd);
            end
            PH_DRIVE: begin
                seq_clutch = CL_RELEASE;
                seq_brake  = BRAKE_OFF;
                seq_rpm    = gear_rpm_target(seq_gear, ts_abs);
                if (req.engine_rpm < RPM_DOWN && seq_gear > GEAR_FIRST &&
                    seq_gear <= GEAR_TOP) begin
                    seq_phase     = PH_PUSH;
                    seq_next_gear = seq_gear - 3'd1;
                end
                if (req.engine_rpm > RPM_UP && seq_gear < GEAR_TOP) begin
                    seq_phase     = PH_PUSH;
                    seq_next_gear = seq_gear + 3'd1;
                end
                stop_or_park(spd);
            end
            default: begin  // stopping
                seq_clutch = CL_SLOW;
                seq_brake  = BRAKE_HOLD;
                seq_rpm    = gear_rpm_target(seq_gear, ts_abs);
                if (ts_abs - spd > SPEED_BAND) seq_phase = PH_RELEASE;
                if (spd < SPEED_BAND && seq_target == 0) seq_phase = PH_PARK;
            end
        endcase
        cmd = {seq_gear, seq_clutch, seq_brake, seq_rpm, seq_phase};
    endtask

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    function automatic step_row_t req_row(logic [7:0] spd, logic [12:0] rpm,
                                          logic [2:0] gear, logic open_flag,
                                          logic closed_flag);
        step_row_t row;
        row.is_cfg  = 1'b0;
        row.reg_sel = CFG_ENABLE;
        row.wdata   = '0;
        row.req     = {spd, rpm, gear, open_flag, closed_flag};
        row.pinned  = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic step_row_t cfg_row(cfg_reg_t sel, logic [8:0] value);
        step_row_t row;
        row         = req_row('0, '0, '0, 1'b0, 1'b0);
        row.is_cfg  = 1'b1;
        row.reg_sel = sel;
        row.wdata   = value;
        return row;
    endfunction

    function automatic step_row_t pinned_row(step_row_t row, out_item_t want);
        row.pinned = 1'b1;
        row.want   = want;
        return row;
    endfunction

    function automatic int clamp_int(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // Target speed: park, both extremes, creep range, full 9-bit range, cruising
    function automatic logic [8:0] pick_target();
        int t;
        case ($urandom_range(0, 7))
            0:       t = 0;
            1:       t = 255;
            2:       t = -255;
            3:       t = int'($urandom_range(1, HOLD_TARGET_MAX));
            4:       t = -int'($urandom_range(1, HOLD_TARGET_MAX));
            5:       t = int'($urandom_range(0, 511));
            default: begin
                t = int'($urandom_range(8, 120));
                if ($urandom_range(0, 1) == 1) t = -t;
            end
        endcase
        return t[8:0];
    endfunction

    // Mostly requests that let the current phase move on; some pure noise
    function automatic in_item_t shape_request();
        in_item_t req;
        int       ts_abs;
        int       spd;
        req.vehicle_speed = 8'($urandom_range(0, 255));
        req.engine_rpm    = 13'($urandom_range(0, RPM_IN_MAX));
        req.gear_now      = 3'($urandom_range(0, 7));
        req.clutch_open   = 1'($urandom_range(0, 1));
        req.clutch_closed = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) return req;

        ts_abs = (seq_target < 0) ? -seq_target : seq_target;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: spd = clamp_int(ts_abs + int'($urandom_range(0, 8)) - 4, 255);
            4, 5, 6:    spd = int'($urandom_range(0, 15));
            7:          spd = int'($urandom_range(0, 1));
            8:          spd = clamp_int(int'(s_data.vehicle_speed) +
                                        int'($urandom_range(0, 6)) - 3, 255);
            default:    spd = int'(req.vehicle_speed);
        endcase
        req.vehicle_speed = spd[7:0];

        case (seq_phase)
            PH_PUSH: req.clutch_open = ($urandom_range(0, 9) < 7);
            PH_GEAR: if ($urandom_range(0, 3) != 0) req.gear_now = seq_gear;
            PH_RPM: begin
                spd = clamp_int(int'(gear_rpm_target(seq_gear, spd)) +
                                int'($urandom_range(0, 1200)) - 600, RPM_IN_MAX);
                req.engine_rpm = spd[12:0];
            end
            PH_DRIVE: begin
                case ($urandom_range(0, 2))
                    0:       req.engine_rpm = 13'($urandom_range(0, RPM_DOWN - 1));
                    1:       req.engine_rpm = 13'($urandom_range(RPM_DOWN, RPM_UP));
                    default: req.engine_rpm = 13'($urandom_range(RPM_UP + 1, RPM_IN_MAX));
                endcase
            end
            default: ;
        endcase
        return req;
    endfunction

    //------------------------------------------------------------------
    // Channel drivers
    //------------------------------------------------------------------

    // One request: optional gap, then hold valid until taken. Valid stays up
    // across back-to-back requests; the model steps at the accepting edge.
    task automatic send_request(in_item_t req, bit pinned, out_item_t pinned_cmd);
        int        gap;
        bit        emits;
        out_item_t cmd;
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        step_sequencer(req, emits, cmd);
        if (emits) begin
            commands_due.push_back(pinned ? pinned_cmd : cmd);
            ticks_checked++;
        end
    endtask

    // Register write only with the pipe empty. Disabled requests leave no
    // command behind, so give the pipe a few cycles after the queue drains.
    task automatic program_register(cfg_reg_t sel, logic [8:0] value);
        s_valid <= 1'b0;
        while (commands_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (sel == CFG_ENABLE) begin
            if (value[0]) seq_en = 1'b1;
            else park_sequencer();
        end else begin
            seq_target = $signed(value);
        end
    endtask

    //------------------------------------------------------------------
    // Command sink and checker
    //------------------------------------------------------------------
    initial begin : command_sink
        int        stall;
        out_item_t want;
        @(posedge aresetn);
        forever begin
            stall = (quiet || draining) ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (commands_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR: command with no request outstanding: %p", m_data);
            end else begin
                want = commands_due.pop_front();
                if (m_data.gear_request   !== want.gear_request   ||
                    m_data.clutch_command !== want.clutch_command ||
                    m_data.brake_level    !== want.brake_level    ||
                    m_data.rpm_request    !== want.rpm_request    ||
                    m_data.mode           !== want.mode) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"ERROR: command mismatch at %0t: expected gear %0d ",
                                  "clutch %0d brake %0d rpm %0d mode %0d, got gear %0d ",
                                  "clutch %0d brake %0d rpm %0d mode %0d"}, $realtime,
                                 want.gear_request, want.clutch_command,
                                 want.brake_level, want.rpm_request, want.mode,
                                 m_data.gear_request, m_data.clutch_command,
                                 m_data.brake_level, m_data.rpm_request, m_data.mode);
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) === 1'b1 || (m_valid && m_ready) === 1'b1 ||
            (cfg_valid && cfg_ready) === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial begin : stimulus
        int        burst;
        step_row_t script[$];
        park_sequencer();

        // Directed walk: forward launch to an upshift with saturated rpm,
        // reverse launch, park at zero target, overspeed stop in neutral,
        // then creep target into clutch hold and back.
        script = '{
            req_row(8'd255, 13'd8191, 3'd7, 1'b1, 1'b1),   // disabled: no command
            req_row(8'd0, 13'd0, 3'd0, 1'b0, 1'b0),
            cfg_row(CFG_ENABLE, 9'd1),
            pinned_row(req_row(8'd0, 13'd0, 3'd0, 1'b0, 1'b0),
                       {GEAR_NEUTRAL, CL_PRESS, BRAKE_LAUNCH, RPM_IDLE, PH_PARK}),
            cfg_row(CFG_TARGET, 9'd255),
            pinned_row(req_row(8'd0, 13'd0, 3'd0, 1'b0, 1'b0),
                       {GEAR_NEUTRAL, CL_PRESS, BRAKE_LAUNCH, RPM_IDLE, PH_PUSH}),
            req_row(8'd0, 13'd0, 3'd0, 1'b1, 1'b0),        // clutch open -> gear
            req_row(8'd0, 13'd8191, 3'd1, 1'b0, 1'b0),     // first engaged -> rpm
            req_row(8'd10, 13'd1169, 3'd1, 1'b0, 1'b0),    // rpm matched -> release
            req_row(8'd10, 13'd1169, 3'd1, 1'b1, 1'b1),    // closed -> drive
            pinned_row(req_row(8'd255, 13'd2001, 3'd1, 1'b0, 1'b1),
                       {GEAR_FIRST, CL_RELEASE, BRAKE_OFF, RPM_MAX, PH_PUSH}),
            req_row(8'd255, 13'd0, 3'd0, 1'b1, 1'b0),
            cfg_row(CFG_ENABLE, 9'd0),
            cfg_row(CFG_TARGET, 9'h101),                    // -255
            cfg_row(CFG_ENABLE, 9'd1),
            req_row(8'd0, 13'd0, 3'd0, 1'b0, 1'b0),        // park -> push, reverse
            req_row(8'd3, 13'd0, 3'd0, 1'b1, 1'b0),
            req_row(8'd3, 13'd0, 3'd6, 1'b0, 1'b0),
            req_row(8'd5, 13'd800, 3'd6, 1'b0, 1'b0),
            req_row(8'd5, 13'd900, 3'd6, 1'b0, 1'b1),
            cfg_row(CFG_TARGET, 9'd0),
            pinned_row(req_row(8'd1, 13'd1500, 3'd6, 1'b0, 1'b1),
                       {GEAR_REVERSE, CL_RELEASE, BRAKE_OFF, RPM_FLOOR, PH_PARK}),
            cfg_row(CFG_TARGET, 9'd5),
            req_row(8'd255, 13'd8191, 3'd0, 1'b0, 1'b0),
            req_row(8'd255, 13'd0, 3'd0, 1'b0, 1'b0),      // overspeed -> stopping
            pinned_row(req_row(8'd200, 13'd0, 3'd0, 1'b0, 1'b0),
                       {GEAR_NEUTRAL, CL_SLOW, BRAKE_HOLD, RPM_FLOOR, PH_STOP}),
            req_row(8'd0, 13'd0, 3'd0, 1'b0, 1'b0),        // below target -> release
            req_row(8'd6, 13'd0, 3'd0, 1'b1, 1'b0),        // creep overspeed -> hold
            req_row(8'd0, 13'd0, 3'd0, 1'b0, 1'b0)         // back to release
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg)
                program_register(script[i].reg_sel, script[i].wdata);
            else
                send_request(script[i].req, script[i].pinned, script[i].want);
        end

        // Random segments: new target each time, sometimes a full disable
        // with a few ignored requests, sometimes a redundant enable.
        while (ticks_checked < RANDOM_TICKS) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 7))
                0: begin
                    program_register(CFG_ENABLE, 9'd0);
                    burst = $urandom_range(1, 6);
                    repeat (burst) send_request(shape_request(), 1'b0, '0);
                    program_register(CFG_TARGET, pick_target());
                    program_register(CFG_ENABLE, 9'd1);
                end
                1: begin
                    program_register(CFG_ENABLE, 9'd1);
                    program_register(CFG_TARGET, pick_target());
                end
                default: program_register(CFG_TARGET, pick_target());
            endcase
            burst = $urandom_range(20, 60);
            repeat (burst) send_request(shape_request(), 1'b0, '0);
        end

        draining = 1'b1;
        s_valid <= 1'b0;
        while (commands_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
